@@ design/speed_fault_supervisor_macros.svh @@
// Assertion macros for the speed fault supervisor.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SPEED_FAULT_SUPERVISOR_MACROS_SVH
`define SPEED_FAULT_SUPERVISOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define SFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sfs_pkg.sv @@
// Types and constants for the speed fault supervisor.
// No dependencies; used by every module of the block.
package sfs_pkg;

  localparam int SPEED_BITS    = 20;
  localparam int TGT_BITS      = SPEED_BITS - 1;
  localparam int INH_BITS      = 8;
  localparam int RUN_BITS      = 8;
  localparam int REC_BITS      = 10;
  localparam int RETRY_BITS    = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = TGT_BITS;

  localparam logic [RUN_BITS-1:0]   RUN_MAX             = {RUN_BITS{1'b1}};
  localparam logic [INH_BITS-1:0]   RST_INHIBIT_TICKS   = INH_BITS'(20);
  localparam logic [TGT_BITS-1:0]   RST_ERROR_THRESHOLD = TGT_BITS'(480);
  localparam logic [TGT_BITS-1:0]   RST_MIN_TARGET      = TGT_BITS'(800);
  localparam logic [RUN_BITS-1:0]   RST_FAULT_TICKS     = RUN_BITS'(10);
  localparam logic [REC_BITS-1:0]   RST_RECOVERY_WAIT   = REC_BITS'(30);
  localparam logic [RETRY_BITS-1:0] RST_MAX_RETRIES     = RETRY_BITS'(3);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SPEED  = 2'd1,
    MODE_LOCKED = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CLR_NONE    = 2'd0,
    CLR_CLEARED = 2'd1,
    CLR_IGNORED = 2'd2
  } clr_res_t;

  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_RAISED = 2'd1,
    EVT_RETRY  = 2'd2,
    EVT_LOCKED = 2'd3
  } evt_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_INHIBIT_TICKS   = 3'd0,
    CFG_ERROR_THRESHOLD = 3'd1,
    CFG_MIN_TARGET      = 3'd2,
    CFG_FAULT_TICKS     = 3'd3,
    CFG_RECOVERY_WAIT   = 3'd4,
    CFG_MAX_RETRIES     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [TGT_BITS-1:0]          target_speed;
    logic signed [SPEED_BITS-1:0] measured_speed;
    logic                         clear_request;
  } in_t;

  typedef struct packed {
    logic [1:0]            fault_mode;
    logic                  drive_off;
    logic                  restart_pulse;
    logic [1:0]            clear_result;
    logic [1:0]            fault_event;
    logic [RETRY_BITS-1:0] retry_number;
  } out_t;

  typedef struct packed {
    logic [INH_BITS-1:0]   inhibit_ticks;
    logic [TGT_BITS-1:0]   error_threshold;
    logic [TGT_BITS-1:0]   min_target;
    logic [RUN_BITS-1:0]   fault_ticks;
    logic [REC_BITS-1:0]   recovery_wait;
    logic [RETRY_BITS-1:0] max_retries;
  } cfg_t;

endpackage

@@ design/sfs_cfg.sv @@
// Configuration register file of the speed fault supervisor.
// Depends on sfs_pkg.
module sfs_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sfs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sfs_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output sfs_pkg::cfg_t                     cfg
);

  sfs_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inhibit_ticks   <= sfs_pkg::RST_INHIBIT_TICKS;
      cfg_r.error_threshold <= sfs_pkg::RST_ERROR_THRESHOLD;
      cfg_r.min_target      <= sfs_pkg::RST_MIN_TARGET;
      cfg_r.fault_ticks     <= sfs_pkg::RST_FAULT_TICKS;
      cfg_r.recovery_wait   <= sfs_pkg::RST_RECOVERY_WAIT;
      cfg_r.max_retries     <= sfs_pkg::RST_MAX_RETRIES;
    end else if (cfg_we) begin
      case (cfg_index)
        sfs_pkg::CFG_INHIBIT_TICKS:
          cfg_r.inhibit_ticks <= cfg_data[sfs_pkg::INH_BITS-1:0];
        sfs_pkg::CFG_ERROR_THRESHOLD:
          cfg_r.error_threshold <= cfg_data[sfs_pkg::TGT_BITS-1:0];
        sfs_pkg::CFG_MIN_TARGET:
          cfg_r.min_target <= cfg_data[sfs_pkg::TGT_BITS-1:0];
        sfs_pkg::CFG_FAULT_TICKS:
          cfg_r.fault_ticks <= cfg_data[sfs_pkg::RUN_BITS-1:0];
        sfs_pkg::CFG_RECOVERY_WAIT:
          cfg_r.recovery_wait <= cfg_data[sfs_pkg::REC_BITS-1:0];
        sfs_pkg::CFG_MAX_RETRIES:
          cfg_r.max_retries <= cfg_data[sfs_pkg::RETRY_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/sfs_step.sv @@
// Per-tick supervisor state and next-state logic.
// Depends on sfs_pkg; state advances on each request handed to the result register.
module sfs_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  sfs_pkg::in_t  item,
  input  sfs_pkg::cfg_t cfg,
  output sfs_pkg::out_t result
);

  sfs_pkg::mode_t                    mode_r, mode_nxt;
  logic [sfs_pkg::RUN_BITS-1:0]      bad_r, bad_nxt;
  logic [sfs_pkg::REC_BITS-1:0]      rec_r, rec_nxt;
  logic [sfs_pkg::RETRY_BITS-1:0]    ret_r, ret_nxt;
  logic [sfs_pkg::INH_BITS-1:0]      inh_r, inh_nxt;
  logic [sfs_pkg::TGT_BITS-1:0]      prev_r, prev_nxt;

  logic signed [sfs_pkg::SPEED_BITS:0] shortfall;
  logic signed [sfs_pkg::SPEED_BITS:0] thr_ext;
  logic [sfs_pkg::RUN_BITS-1:0]        bad_inc;
  logic                                drive_off;
  logic                                restart;
  sfs_pkg::clr_res_t                   clr_res;
  sfs_pkg::evt_t                       evt;

  assign shortfall = $signed({2'b00, item.target_speed})
                   - $signed({item.measured_speed[sfs_pkg::SPEED_BITS-1],
                              item.measured_speed});
  assign thr_ext   = $signed({2'b00, cfg.error_threshold});

  always_comb begin
    mode_nxt  = mode_r;
    bad_nxt   = bad_r;
    rec_nxt   = rec_r;
    ret_nxt   = ret_r;
    inh_nxt   = inh_r;
    prev_nxt  = prev_r;
    drive_off = 1'b0;
    restart   = 1'b0;
    clr_res   = sfs_pkg::CLR_NONE;
    evt       = sfs_pkg::EVT_NONE;

    if (item.clear_request) begin
      if (mode_r == sfs_pkg::MODE_LOCKED) begin
        mode_nxt  = sfs_pkg::MODE_NORMAL;
        ret_nxt   = '0;
        bad_nxt   = '0;
        inh_nxt   = cfg.inhibit_ticks;
        restart   = 1'b1;
        drive_off = 1'b1;
        clr_res   = sfs_pkg::CLR_CLEARED;
      end else begin
        clr_res   = sfs_pkg::CLR_IGNORED;
      end
    end

    if (item.target_speed != prev_r) begin
      prev_nxt = item.target_speed;
      inh_nxt  = cfg.inhibit_ticks;
      bad_nxt  = '0;
    end

    bad_inc = (bad_nxt == sfs_pkg::RUN_MAX) ? bad_nxt
            : sfs_pkg::RUN_BITS'(bad_nxt + 1'b1);

    case (mode_nxt)
      sfs_pkg::MODE_NORMAL: begin
        if (inh_nxt != '0) begin
          inh_nxt = inh_nxt - 1'b1;
        end else if (item.target_speed >= cfg.min_target) begin
          if (shortfall > thr_ext) begin
            if (bad_inc >= cfg.fault_ticks) begin
              mode_nxt  = sfs_pkg::MODE_SPEED;
              bad_nxt   = '0;
              rec_nxt   = cfg.recovery_wait;
              drive_off = 1'b1;
              evt       = sfs_pkg::EVT_RAISED;
            end else begin
              bad_nxt   = bad_inc;
            end
          end else begin
            bad_nxt = '0;
          end
        end else begin
          bad_nxt = '0;
        end
      end
      sfs_pkg::MODE_SPEED: begin
        drive_off = 1'b1;
        if (rec_r != '0) begin
          rec_nxt = rec_r - 1'b1;
        end else if (ret_r < cfg.max_retries) begin
          ret_nxt  = ret_r + 1'b1;
          restart  = 1'b1;
          mode_nxt = sfs_pkg::MODE_NORMAL;
          inh_nxt  = cfg.inhibit_ticks;
          evt      = sfs_pkg::EVT_RETRY;
        end else begin
          mode_nxt = sfs_pkg::MODE_LOCKED;
          evt      = sfs_pkg::EVT_LOCKED;
        end
      end
      default: begin
        drive_off = 1'b1;
      end
    endcase

    result.fault_mode    = mode_nxt;
    result.drive_off     = drive_off;
    result.restart_pulse = restart;
    result.clear_result  = clr_res;
    result.fault_event   = evt;
    result.retry_number  = ret_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sfs_pkg::MODE_NORMAL;
      bad_r  <= '0;
      rec_r  <= '0;
      ret_r  <= '0;
      inh_r  <= '0;
      prev_r <= '0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      bad_r  <= bad_nxt;
      rec_r  <= rec_nxt;
      ret_r  <= ret_nxt;
      inh_r  <= inh_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

@@ design/speed_fault_supervisor.sv @@
// Speed fault supervisor top level: input register, step logic, result register.
// Depends on sfs_pkg, sfs_cfg, sfs_step and speed_fault_supervisor_macros.svh.
//
//   port group | handshake            | payload
//   in_        | in_valid / in_ready  | in_data  (sfs_pkg::in_t)
//   out_       | out_valid / out_ready| out_data (sfs_pkg::out_t)
//   cfg_       | cfg_we               | cfg_index, cfg_data
//
// One request per cycle sustained while out_ready stays high; each request waits in the input
// register, where the step logic evaluates it, and then lands in the result register.
// out_valid rises when a request moves into the result register and stays high until out_ready.
// Synchronous active-low reset restores the register defaults and normal mode.
// A stalled result register holds the input register, which then drops in_ready.
`include "speed_fault_supervisor_macros.svh"

module speed_fault_supervisor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sfs_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sfs_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [sfs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sfs_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  sfs_pkg::cfg_t cfg;
  sfs_pkg::in_t  hold_data_r;
  sfs_pkg::out_t out_data_r;
  sfs_pkg::out_t step_result;
  logic          hold_valid_r, hold_valid_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          in_fire;
  logic          advance;

  sfs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfs_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (hold_data_r),
    .cfg     (cfg),
    .result  (step_result)
  );

  assign advance  = hold_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !hold_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_fire) begin
      hold_valid_nxt = 1'b1;
    end else if (advance) begin
      hold_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SFS_ASSERT_IMP(a_stall_full, !in_ready,
    hold_valid_r && out_valid_r && !out_ready, "in_ready low without a full pipeline")
  `SFS_ASSERT_IMP(a_locked_drive_off,
    out_valid_r && (out_data_r.fault_mode == sfs_pkg::MODE_LOCKED),
    out_data_r.drive_off, "locked result without drive_off")
  `SFS_ASSERT_NXT(a_raise_to_speed,
    advance && (step_result.fault_event == sfs_pkg::EVT_RAISED),
    out_valid_r && (out_data_r.fault_mode == sfs_pkg::MODE_SPEED),
    "raised fault not reported in speed fault mode")

endmodule
